FILE: hdl/rlcs_pkg.sv
// ----------------------------------------------------------------------------
// rlcs_pkg
// shared constants and types for the run-length character store
// ----------------------------------------------------------------------------
package rlcs_pkg;

    localparam int MaxRuns   = 256;
    localparam int MaxTotal  = 65535;
    localparam int RunIdxW   = $clog2(MaxRuns);
    localparam int RunCntW   = RunIdxW + 1;
    localparam int CountW    = 16;
    localparam int CharW     = 8;
    localparam int RunW      = CharW + CountW;

    localparam logic [CountW-1:0] CountMax = '1;

    // commands
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_GET    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NULL   = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;
    localparam logic [1:0] ST_OOM    = 2'd3;

    typedef struct packed {
        logic [CharW-1:0]  ch;
        logic [CountW-1:0] count;
    } run_t;

endpackage

FILE: hdl/rlcs_ram.sv
// ----------------------------------------------------------------------------
// rlcs_ram
// generic simple dual-port synchronous ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module rlcs_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/run_length_character_store.sv
// ----------------------------------------------------------------------------
// run_length_character_store
// character sequence kept as an ordered table of (character, count) runs
// ----------------------------------------------------------------------------
// One command item in, one result item out. The run table lives in one
// simple dual-port ram with a registered read. Append reads the last run
// if there is one, then writes. Get scans runs one per cycle until the run
// holding the position. Remove scans the same way, then either decrements
// the run in place, or deletes it and shifts the table tail down one entry
// per read state and write state. The run scan and the tail shift set the rate.
// The next item is accepted once the result register is free and the
// sequencer is back to idle.
module run_length_character_store
    import rlcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tuser,   // command[1:0]
    input  logic [23:0] s_tdata,   // char_in[7:0], position[23:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // char_out[7:0], status[9:8], length[25:10]
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_APRD   = 4'd1;
    localparam logic [3:0] S_APCHK  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_RMPREV = 4'd4;
    localparam logic [3:0] S_RMNEXT = 4'd5;
    localparam logic [3:0] S_RMDEC  = 4'd6;
    localparam logic [3:0] S_SHRD   = 4'd7;
    localparam logic [3:0] S_SHWR   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_MRGWR  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [RunCntW-1:0] used_reg, used_next;
    logic [CountW-1:0]  total_reg, total_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [CharW-1:0]   chr_reg, chr_next;
    logic [CountW-1:0]  pos_reg, pos_next;
    logic [RunCntW-1:0] idx_reg, idx_next;
    logic [CountW:0]    acc_reg, acc_next;
    logic [1:0]         st_reg, st_next;
    logic [CharW-1:0]   found_reg, found_next;
    logic [RunCntW-1:0] del_reg, del_next;
    run_t               prev_reg, prev_next;
    logic               mvalid_reg, mvalid_next;
    logic [31:0]        mdata_reg, mdata_next;

    logic               ram_we;
    logic [RunIdxW-1:0] ram_waddr, ram_raddr;
    run_t               ram_wdata, ram_rdata;
    logic [CountW:0]    acc_sum;
    logic [CountW:0]    mrg_sum;

    rlcs_ram #(.Width(RunW), .Depth(MaxRuns)) u_runs (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign acc_sum  = acc_reg + {1'b0, ram_rdata.count};
    assign mrg_sum  = {1'b0, prev_reg.count} + {1'b0, ram_rdata.count};

    // sequencer
    always_comb begin
        state_next  = state_reg;
        used_next   = used_reg;
        total_next  = total_reg;
        cmd_next    = cmd_reg;
        chr_next    = chr_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        acc_next    = acc_reg;
        st_next     = st_reg;
        found_next  = found_reg;
        del_next    = del_reg;
        prev_next   = prev_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[RunIdxW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[RunIdxW-1:0];

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd_next   = s_tuser[1:0];
                    chr_next   = s_tdata[7:0];
                    pos_next   = s_tdata[23:8];
                    st_next    = ST_OK;
                    found_next = '0;
                    acc_next   = '0;
                    idx_next   = '0;
                    state_next = S_DONE;
                    if (s_tuser[1:0] == CMD_APPEND) begin
                        if (s_tdata[7:0] == '0) begin
                            st_next = ST_NULL;
                        end else if (total_reg >= CountW'(MaxTotal)) begin
                            st_next = ST_OOM;
                        end else if (used_reg == '0) begin
                            idx_next   = '0;
                            state_next = S_APCHK;
                        end else begin
                            idx_next   = used_reg - 1'b1;
                            state_next = S_APRD;
                        end
                    end else if (s_tuser[1:0] == CMD_GET
                                 || s_tuser[1:0] == CMD_REMOVE) begin
                        if (s_tdata[23:8] >= total_reg || used_reg == '0) begin
                            st_next = ST_BOUNDS;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_APRD: begin
                // read of the last run is issued; data arrives next cycle
                state_next = S_APCHK;
            end
            S_APCHK: begin
                if (used_reg != '0 && ram_rdata.ch == chr_reg) begin
                    if (ram_rdata.count >= CountMax) begin
                        st_next = ST_OOM;
                    end else begin
                        ram_we          = 1'b1;
                        ram_wdata.ch    = chr_reg;
                        ram_wdata.count = ram_rdata.count + 1'b1;
                        total_next      = total_reg + 1'b1;
                    end
                end else if (used_reg >= RunCntW'(MaxRuns)) begin
                    st_next = ST_OOM;
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = used_reg[RunIdxW-1:0];
                    ram_wdata.ch    = chr_reg;
                    ram_wdata.count = CountW'(1);
                    used_next       = used_reg + 1'b1;
                    total_next      = total_reg + 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN: begin
                // one run per cycle: the read of idx lands in the next cycle
                if (acc_reg != '0 || idx_reg != '0) begin
                    // data for idx_reg - 1 is valid
                    if ({1'b0, pos_reg} < acc_sum) begin
                        idx_next = idx_reg - 1'b1;
                        if (cmd_reg == CMD_GET) begin
                            found_next = ram_rdata.ch;
                            state_next = S_DONE;
                        end else begin
                            prev_next  = ram_rdata;
                            total_next = total_reg - 1'b1;
                            state_next = S_RMDEC;
                        end
                    end else begin
                        acc_next   = acc_sum;
                        idx_next   = idx_reg + 1'b1;
                    end
                end else begin
                    // first cycle: read of run 0 is issued
                    acc_next  = '0;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_RMDEC: begin
                // prev_reg holds the found run, idx_reg its index
                if (prev_reg.count > CountW'(1)) begin
                    ram_we          = 1'b1;
                    ram_wdata.ch    = prev_reg.ch;
                    ram_wdata.count = prev_reg.count - 1'b1;
                    state_next      = S_DONE;
                end else if (idx_reg != '0 && idx_reg + 1'b1 < used_reg) begin
                    chr_next   = prev_reg.ch;
                    ram_raddr  = RunIdxW'(idx_reg - 1'b1);
                    state_next = S_RMPREV;
                end else begin
                    del_next   = RunCntW'(1);
                    idx_next   = idx_reg + 1'b1;
                    ram_raddr  = RunIdxW'(idx_reg + 1'b1);
                    state_next = S_SHRD;
                end
            end
            S_RMPREV: begin
                // ram_rdata is run idx-1 now; keep it and read run idx+1
                prev_next  = ram_rdata;
                ram_raddr  = RunIdxW'(idx_reg + 1'b1);
                state_next = S_RMNEXT;
            end
            S_RMNEXT: begin
                // ram_rdata is run idx+1; hold the read for the merge check
                ram_raddr  = RunIdxW'(idx_reg + 1'b1);
                state_next = S_MRGWR;
            end
            S_MRGWR: begin
                if (prev_reg.ch == ram_rdata.ch && !mrg_sum[CountW]) begin
                    ram_we          = 1'b1;
                    ram_waddr       = RunIdxW'(idx_reg - 1'b1);
                    ram_wdata.ch    = prev_reg.ch;
                    ram_wdata.count = mrg_sum[CountW-1:0];
                    del_next        = RunCntW'(2);
                    idx_next        = idx_reg + 2'd2;
                    ram_raddr       = RunIdxW'(idx_reg + 2'd2);
                end else begin
                    del_next  = RunCntW'(1);
                    idx_next  = idx_reg + 1'b1;
                    ram_raddr = RunIdxW'(idx_reg + 1'b1);
                end
                state_next = S_SHRD;
            end
            S_SHRD: begin
                // idx_reg is the source entry; its read was issued last cycle
                if (idx_reg >= used_reg) begin
                    used_next  = used_reg - del_reg;
                    state_next = S_DONE;
                end else begin
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                ram_we     = 1'b1;
                ram_waddr  = RunIdxW'(idx_reg - del_reg);
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + 1'b1;
                ram_raddr  = RunIdxW'(idx_reg + 1'b1);
                state_next = S_SHRD;
            end
            S_DONE: begin
                if (!mvalid_reg) begin
                    mvalid_next = 1'b1;
                    mdata_next  = {6'd0, total_reg, st_reg, found_reg};
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            total_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            total_reg  <= total_next;
            mvalid_reg <= mvalid_next;
        end
        cmd_reg   <= cmd_next;
        chr_reg   <= chr_next;
        pos_reg   <= pos_next;
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        st_reg    <= st_next;
        found_reg <= found_next;
        del_reg   <= del_next;
        prev_reg  <= prev_next;
        mdata_reg <= mdata_next;
    end

    // run count never exceeds the table size
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= RunCntW'(MaxRuns))
        else $error("run count above table size");

    // no input accepted while a result waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg |-> !s_tready)
        else $error("accept while result pending");

    // empty store has no characters
    a_empty_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_reg == '0 && state_reg == S_IDLE) |-> total_reg == '0)
        else $error("empty table with nonzero length");

    // length changes by at most one per item
    a_total_step: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != $past(total_reg) |->
            (total_reg == $past(total_reg) + 1'b1
             || total_reg == $past(total_reg) - 1'b1))
        else $error("length jumped");

endmodule

FILE: tb/sv/run_length_character_store_checker.sv
// ----------------------------------------------------------------------------
// run_length_character_store_checker
// watches both channels, predicts every result item and compares it
// ----------------------------------------------------------------------------
module run_length_character_store_checker
    import rlcs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tuser,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  ch;
        logic [1:0]  st;
        logic [15:0] len;
    } answer_t;

    logic [7:0]  seq_chars [MaxRuns];
    logic [16:0] seq_counts [MaxRuns];
    int          seq_runs;
    int          seq_total;
    answer_t     answers [$];

    assign pending = answers.size();

    // run holding a position; caller checks the bound
    function automatic int locate_run(int pos);
        int acc;
        acc = 0;
        for (int i = 0; i < seq_runs; i++) begin
            acc += seq_counts[i];
            if (pos < acc) return i;
        end
        return seq_runs - 1;
    endfunction

    // drop n runs starting at at, shifting the tail down
    task automatic drop_runs(int at, int n);
        for (int i = at; i + n < seq_runs; i++) begin
            seq_chars[i]  = seq_chars[i + n];
            seq_counts[i] = seq_counts[i + n];
        end
        seq_runs -= n;
    endtask

    // apply one command item to the shadow table and return its answer
    task automatic apply_command(logic [1:0] cmd, logic [7:0] c, logic [15:0] pos,
                                 output answer_t a);
        int r;
        a.ch = '0;
        a.st = ST_OK;
        if (cmd == CMD_APPEND) begin
            if (c == 0) a.st = ST_NULL;
            else if (seq_total >= MaxTotal) a.st = ST_OOM;
            else if (seq_runs > 0 && seq_chars[seq_runs-1] == c) begin
                if (seq_counts[seq_runs-1] >= CountMax) a.st = ST_OOM;
                else begin
                    seq_counts[seq_runs-1]++;
                    seq_total++;
                end
            end else if (seq_runs >= MaxRuns) a.st = ST_OOM;
            else begin
                seq_chars[seq_runs]  = c;
                seq_counts[seq_runs] = 17'd1;
                seq_runs++;
                seq_total++;
            end
        end else if (cmd == CMD_GET) begin
            if (pos >= seq_total || seq_runs == 0) a.st = ST_BOUNDS;
            else a.ch = seq_chars[locate_run(pos)];
        end else if (cmd == CMD_REMOVE) begin
            if (pos >= seq_total || seq_runs == 0) a.st = ST_BOUNDS;
            else begin
                r = locate_run(pos);
                seq_total--;
                if (seq_counts[r] > 1) seq_counts[r]--;
                else if (r > 0 && r + 1 < seq_runs && seq_chars[r-1] == seq_chars[r+1] &&
                         seq_counts[r-1] + seq_counts[r+1] <= CountMax) begin
                    seq_counts[r-1] += seq_counts[r+1];
                    drop_runs(r, 2);
                end else drop_runs(r, 1);
            end
        end
        a.len = seq_total[15:0];
    endtask

    // predict on accepted input items, compare on accepted result items
    always @(posedge aclk) begin
        answer_t a, want;
        if (!aresetn) begin
            seq_runs   = 0;
            seq_total  = 0;
            fail_count <= 0;
            answers.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                apply_command(s_tuser[1:0], s_tdata[7:0], s_tdata[23:8], a);
                answers.push_back(a);
            end
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers.pop_front();
                    if (m_tdata[7:0] != want.ch || m_tdata[9:8] != want.st ||
                        m_tdata[25:10] != want.len || m_tdata[31:26] != 0) begin
                        $display({"%0t: mismatch expected ch=%h st=%0d len=%0d,",
                                  " got ch=%h st=%0d len=%0d"},
                                 $time, want.ch, want.st, want.len,
                                 m_tdata[7:0], m_tdata[9:8], m_tdata[25:10]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/run_length_character_store_test.sv
// ----------------------------------------------------------------------------
// run_length_character_store_test
// stimulus and verdict for the run-length character store
// ----------------------------------------------------------------------------
// Directed edge cases first (null char, empty store, merges, full table),
// then random command mixes over a small alphabet with random stalls.
module run_length_character_store_test
    import rlcs_pkg::*;
();

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tuser = '0;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    int          total_len;

    always #2 aclk = ~aclk;

    run_length_character_store dut (.*);

    run_length_character_store_checker chk (.*);

    // rough shadow of the length, used only to aim positions
    always @(posedge aclk) if (m_tvalid && m_tready) total_len <= m_tdata[25:10];

    // valid stays high between back-to-back items
    task automatic send_item(logic [1:0] cmd, logic [7:0] c, logic [15:0] pos);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= {6'd0, cmd};
        s_tdata  <= {pos, c};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [15:0] aim_pos();
        if (total_len == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, total_len));
    endfunction

    // result side stalls
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            w = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed
        send_item(CMD_GET, 8'h00, 16'h0000);
        send_item(CMD_REMOVE, 8'h00, 16'hFFFF);
        send_item(CMD_APPEND, 8'h00, 16'h0000);
        send_item(CMD_APPEND, 8'hFF, 16'hFFFF);
        send_item(CMD_APPEND, 8'hFF, 16'h0000);
        send_item(CMD_APPEND, 8'h01, 16'h0000);
        send_item(CMD_APPEND, 8'hFF, 16'h0000);
        send_item(CMD_GET, 8'h00, 16'd2);
        send_item(CMD_GET, 8'h00, 16'd4);
        send_item(CMD_REMOVE, 8'h00, 16'd2);   // merge of equal neighbors
        send_item(CMD_GET, 8'h00, 16'd2);
        send_item(CMD_REMOVE, 8'h00, 16'd0);
        send_item(CMD_UNUSED, 8'hAA, 16'h5555);
        send_item(CMD_APPEND, 8'h02, 16'h0000);
        send_item(CMD_REMOVE, 8'h00, 16'd3);   // position past the end
        send_item(CMD_REMOVE, 8'h00, 16'd0);
        send_item(CMD_REMOVE, 8'h00, 16'd0);
        send_item(CMD_REMOVE, 8'h00, 16'd0);   // empty again
        // fill the run table past its limit
        for (int i = 0; i < MaxRuns + 2; i++)
            send_item(CMD_APPEND, (i % 2) ? 8'h55 : 8'hAA, 16'd0);
        send_item(CMD_GET, 8'h00, 16'd255);
        for (int i = 0; i < 40; i++) send_item(CMD_REMOVE, 8'h00, aim_pos());
        // random mix
        for (int i = 0; i < 330; i++) begin
            int k;
            k = $urandom_range(0, 19);
            if (k < 9) send_item(CMD_APPEND, ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                                  8'($urandom_range(0, 3)), 16'($urandom));
            else if (k < 14) send_item(CMD_GET, 8'($urandom), aim_pos());
            else if (k < 19) send_item(CMD_REMOVE, 8'($urandom), aim_pos());
            else send_item(CMD_UNUSED, 8'($urandom), 16'($urandom));
        end
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered appends, gets and removes incl. merges, null chars, full table");
        $display("and out-of-range positions with random stalls on both channels");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
